>>> src/piecewise_linear_color_map_top_macros.svh
// Assertion macros used by the color map top module.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PIECEWISE_LINEAR_COLOR_MAP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_COLOR_MAP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PLCM_ASSERT_COMB(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PLCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLCM_ASSERT_COMB(lbl, expr, msg)
`define PLCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/plcm_pkg.sv
package plcm_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 5;
    localparam int INDEX_WIDTH     = 4;
    localparam int CH_WIDTH        = 8;
    localparam int N_MIN           = 2;
    localparam int QUOT_BITS       = 8;
    localparam int CFG_RESET       = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    typedef struct packed {
        logic [CH_WIDTH-1:0] red;
        logic [CH_WIDTH-1:0] green;
        logic [CH_WIDTH-1:0] blue;
    } color_t;

    // per-stage control: item present, and color taken as is (no blend)
    typedef struct packed {
        logic valid;
        logic direct;
    } stage_ctl_t;

endpackage

>>> src/plcm_if.sv
interface plcm_in_if import plcm_pkg::*; #(
    parameter int VW = VALUE_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic signed [VW-1:0]   value;
    logic [INDEX_WIDTH-1:0] entry_index;
    logic [CH_WIDTH-1:0]    red_in;
    logic [CH_WIDTH-1:0]    green_in;
    logic [CH_WIDTH-1:0]    blue_in;

    modport source (output valid, op, value, entry_index, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, op, value, entry_index, red_in, green_in, blue_in,
                  output ready);
endinterface

interface plcm_out_if import plcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_WIDTH-1:0] red_out;
    logic [CH_WIDTH-1:0] green_out;
    logic [CH_WIDTH-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface plcm_cfg_if import plcm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> src/piecewise_linear_color_map_top.sv
// Piecewise linear pseudocolor map.
// samples: one transaction per item. op = 1 maps a signed Q8.8 value to a
//   color; op = 0 loads breakpoint and color into entry entry_index and
//   gives no result (indexes at or beyond the table depth are dropped).
// colors: one transaction per map item, in the order the items arrived.
// cfg: writes entries_in_use, the active entry count (held to 2..depth).
//   Always ready; write it only while no map item is in flight.
// Throughput: one item per cycle on every input pattern, unless the receiver stalls.
// Pipeline: the accepting edge loads the input register; then come the
//   breakpoint compare and the neighbor search with its table read, the
//   distances, products and their sum, the restoring divider (one quotient
//   bit per stage) and the output register.
// Reset clears the table to zeros, entries_in_use to 2 and all valid bits.
// When the receiver stalls, the whole pipeline holds: samples.ready drops
//   in the same cycle that colors.valid is high without colors.ready.
`include "piecewise_linear_color_map_top_macros.svh"

module piecewise_linear_color_map_top import plcm_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    plcm_in_if.sink       samples,
    plcm_out_if.source    colors,
    plcm_cfg_if.sink      cfg
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = VALUE_WIDTH + 9;

    logic                          adv;
    logic [CFG_WIDTH-1:0]          entries_reg;
    logic [CW-1:0]                 n_eff;

    // stage A: registered input transaction
    logic                          valid_a_reg;
    logic                          op_a_reg;
    logic signed [VALUE_WIDTH-1:0] value_a_reg;
    logic [INDEX_WIDTH-1:0]        idx_a_reg;
    color_t                        color_a_reg;

    stage_ctl_t                    ctl_c;
    logic signed [VALUE_WIDTH-1:0] value_c;
    logic signed [VALUE_WIDTH-1:0] bp_lo_c;
    logic signed [VALUE_WIDTH-1:0] bp_hi_c;
    color_t                        col_lo_c;
    color_t                        col_hi_c;

    stage_ctl_t                    ctl_f;
    color_t                        dcol_f;
    logic [NW-1:0]                 num_f [3];
    logic [VALUE_WIDTH-1:0]        den_f;

    stage_ctl_t                    ctl_q;
    color_t                        color_q;

    logic                          out_valid_reg;
    color_t                        out_color_reg;

    // advance every stage together unless the result register is held
    assign adv           = !out_valid_reg || colors.ready;
    assign samples.ready = adv;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= CFG_WIDTH'(CFG_RESET);
        end
        else if (cfg.valid)
        begin
            entries_reg <= cfg.data;
        end
    end

    // saturate the active count to the table range
    always_comb
    begin
        priority if (32'(entries_reg) < N_MIN)
        begin
            n_eff = CW'(N_MIN);
        end
        else if (32'(entries_reg) > MAX_ENTRIES)
        begin
            n_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = CW'(entries_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_a_reg          <= samples.op;
            value_a_reg       <= samples.value;
            idx_a_reg         <= samples.entry_index;
            color_a_reg.red   <= samples.red_in;
            color_a_reg.green <= samples.green_in;
            color_a_reg.blue  <= samples.blue_in;
        end
    end

    // table writes commit as the write item leaves stage A
    plcm_search #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CW          (CW)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_a  (valid_a_reg),
        .op_a     (op_a_reg),
        .value_a  (value_a_reg),
        .idx_a    (idx_a_reg),
        .color_a  (color_a_reg),
        .n_eff    (n_eff),
        .ctl_c    (ctl_c),
        .value_c  (value_c),
        .bp_lo_c  (bp_lo_c),
        .bp_hi_c  (bp_hi_c),
        .col_lo_c (col_lo_c),
        .col_hi_c (col_hi_c)
    );

    plcm_blend #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NW          (NW)
    ) u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_c    (ctl_c),
        .value_c  (value_c),
        .bp_lo_c  (bp_lo_c),
        .bp_hi_c  (bp_hi_c),
        .col_lo_c (col_lo_c),
        .col_hi_c (col_hi_c),
        .ctl_f    (ctl_f),
        .dcol_f   (dcol_f),
        .num_f    (num_f),
        .den_f    (den_f)
    );

    plcm_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NW          (NW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_f   (ctl_f),
        .dcol_f  (dcol_f),
        .num_f   (num_f),
        .den_f   (den_f),
        .ctl_q   (ctl_q),
        .color_q (color_q)
    );

    // result register; holds while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_q.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_color_reg <= color_q;
        end
    end

    assign colors.valid     = out_valid_reg;
    assign colors.red_out   = out_color_reg.red;
    assign colors.green_out = out_color_reg.green;
    assign colors.blue_out  = out_color_reg.blue;

    `PLCM_ASSERT_COMB(a_stall_blocks_input, !(colors.valid && !colors.ready) || !samples.ready, "input accepted while result stalled")
    `PLCM_ASSERT_NEXT(a_result_from_pipe, !colors.valid && !ctl_q.valid, !colors.valid, "result appeared with empty pipeline tail")
    `PLCM_ASSERT_COMB(a_count_in_range, (32'(n_eff) >= N_MIN) && (32'(n_eff) <= MAX_ENTRIES), "active entry count out of range")

endmodule

>>> src/plcm_search.sv
module plcm_search import plcm_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_a,
    input  logic                          op_a,
    input  logic signed [VALUE_WIDTH-1:0] value_a,
    input  logic [INDEX_WIDTH-1:0]        idx_a,
    input  color_t                        color_a,
    input  logic [CW-1:0]                 n_eff,
    output stage_ctl_t                    ctl_c,
    output logic signed [VALUE_WIDTH-1:0] value_c,
    output logic signed [VALUE_WIDTH-1:0] bp_lo_c,
    output logic signed [VALUE_WIDTH-1:0] bp_hi_c,
    output color_t                        col_lo_c,
    output color_t                        col_hi_c
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int EW = VALUE_WIDTH + 3 * CH_WIDTH;

    logic signed [VALUE_WIDTH-1:0] bp_reg [MAX_ENTRIES];
    logic [EW-1:0]                 mem_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]        ent_valid_reg;

    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;

    logic [MAX_ENTRIES-1:0]        hit_b_reg;
    logic                          valid_b_reg;
    logic signed [VALUE_WIDTH-1:0] value_b_reg;

    logic                          low_b;
    logic                          found_b;
    logic [CW-1:0]                 i_b;
    logic [IW-1:0]                 addr_lo;
    logic [IW-1:0]                 addr_hi;

    stage_ctl_t                    ctl_c_reg;
    logic signed [VALUE_WIDTH-1:0] value_c_reg;
    logic [EW-1:0]                 rd_lo_reg;
    logic [EW-1:0]                 rd_hi_reg;

    assign wr_en   = adv && valid_a && (op_a == OP_WRITE) && (32'(idx_a) < MAX_ENTRIES);
    assign wr_addr = IW'(idx_a);

    // breakpoint copies feed the comparators, one per entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                bp_reg[k] <= '0;
            end
            ent_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            bp_reg[wr_addr]        <= value_a;
            ent_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= {value_a, color_a};
        end
    end

    // stage B: compare against every active breakpoint
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_b_reg <= valid_a && (op_a == OP_MAP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_b_reg <= value_a;
            hit_b_reg[0] <= (value_a <= bp_reg[0]);
            for (int k = 1; k < MAX_ENTRIES; k++)
            begin
                hit_b_reg[k] <= (k < 32'(n_eff)) && (value_a <= bp_reg[k]);
            end
        end
    end

    // first active breakpoint from index 1 that is not below the value
    always_comb
    begin
        low_b   = hit_b_reg[0];
        found_b = 1'b0;
        i_b     = n_eff;
        for (int k = MAX_ENTRIES - 1; k >= 1; k--)
        begin
            if (hit_b_reg[k])
            begin
                found_b = 1'b1;
                i_b     = CW'(k);
            end
        end
        priority if (low_b)
        begin
            addr_lo = '0;
        end
        else if (found_b)
        begin
            addr_lo = IW'(i_b - CW'(1));
        end
        else
        begin
            addr_lo = IW'(n_eff - CW'(1));
        end
        addr_hi = IW'(i_b);
    end

    // stage C: registered table read at both neighbors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c_reg <= '0;
        end
        else if (adv)
        begin
            ctl_c_reg.valid  <= valid_b_reg;
            ctl_c_reg.direct <= low_b || !found_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_c_reg <= value_b_reg;
            rd_lo_reg   <= ent_valid_reg[addr_lo] ? mem_reg[addr_lo] : '0;
            rd_hi_reg   <= ent_valid_reg[addr_hi] ? mem_reg[addr_hi] : '0;
        end
    end

    assign ctl_c    = ctl_c_reg;
    assign value_c  = value_c_reg;
    assign bp_lo_c  = rd_lo_reg[EW-1:3*CH_WIDTH];
    assign bp_hi_c  = rd_hi_reg[EW-1:3*CH_WIDTH];
    assign col_lo_c = color_t'(rd_lo_reg[3*CH_WIDTH-1:0]);
    assign col_hi_c = color_t'(rd_hi_reg[3*CH_WIDTH-1:0]);

endmodule

>>> src/plcm_blend.sv
module plcm_blend import plcm_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int NW          = VALUE_WIDTH + 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  stage_ctl_t                    ctl_c,
    input  logic signed [VALUE_WIDTH-1:0] value_c,
    input  logic signed [VALUE_WIDTH-1:0] bp_lo_c,
    input  logic signed [VALUE_WIDTH-1:0] bp_hi_c,
    input  color_t                        col_lo_c,
    input  color_t                        col_hi_c,
    output stage_ctl_t                    ctl_f,
    output color_t                        dcol_f,
    output logic [NW-1:0]                 num_f [3],
    output logic [VALUE_WIDTH-1:0]        den_f
);

    localparam int PW = VALUE_WIDTH + CH_WIDTH;

    logic signed [VALUE_WIDTH:0] diff0;
    logic signed [VALUE_WIDTH:0] diff1;
    logic signed [VALUE_WIDTH:0] diffs;

    stage_ctl_t             ctl_d_reg;
    stage_ctl_t             ctl_e_reg;
    stage_ctl_t             ctl_f_reg;
    logic [VALUE_WIDTH-1:0] d0_reg;
    logic [VALUE_WIDTH-1:0] d1_reg;
    logic [VALUE_WIDTH-1:0] den_d_reg;
    logic [VALUE_WIDTH-1:0] den_e_reg;
    logic [VALUE_WIDTH-1:0] den_f_reg;
    color_t                 lo_d_reg;
    color_t                 hi_d_reg;
    color_t                 dcol_e_reg;
    color_t                 dcol_f_reg;
    logic [PW-1:0]          plo_reg [3];
    logic [PW-1:0]          phi_reg [3];
    logic [NW-1:0]          num_reg [3];
    logic [CH_WIDTH-1:0]    ch_lo [3];
    logic [CH_WIDTH-1:0]    ch_hi [3];

    // distances are nonnegative on the blend path, so the low bits carry them
    assign diff0 = {value_c[VALUE_WIDTH-1], value_c} - {bp_lo_c[VALUE_WIDTH-1], bp_lo_c};
    assign diff1 = {bp_hi_c[VALUE_WIDTH-1], bp_hi_c} - {value_c[VALUE_WIDTH-1], value_c};
    assign diffs = {bp_hi_c[VALUE_WIDTH-1], bp_hi_c} - {bp_lo_c[VALUE_WIDTH-1], bp_lo_c};

    assign ch_lo[0] = lo_d_reg.red;
    assign ch_lo[1] = lo_d_reg.green;
    assign ch_lo[2] = lo_d_reg.blue;
    assign ch_hi[0] = hi_d_reg.red;
    assign ch_hi[1] = hi_d_reg.green;
    assign ch_hi[2] = hi_d_reg.blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
        end
        else if (adv)
        begin
            ctl_d_reg <= ctl_c;
            ctl_e_reg <= ctl_d_reg;
            ctl_f_reg <= ctl_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg     <= diff0[VALUE_WIDTH-1:0];
            d1_reg     <= diff1[VALUE_WIDTH-1:0];
            den_d_reg  <= diffs[VALUE_WIDTH-1:0];
            lo_d_reg   <= col_lo_c;
            hi_d_reg   <= col_hi_c;
            den_e_reg  <= den_d_reg;
            dcol_e_reg <= lo_d_reg;
            den_f_reg  <= den_e_reg;
            dcol_f_reg <= dcol_e_reg;
            for (int c = 0; c < 3; c++)
            begin
                plo_reg[c] <= PW'(ch_lo[c]) * PW'(d1_reg);
                phi_reg[c] <= PW'(ch_hi[c]) * PW'(d0_reg);
                num_reg[c] <= NW'(plo_reg[c]) + NW'(phi_reg[c]);
            end
        end
    end

    assign ctl_f  = ctl_f_reg;
    assign dcol_f = dcol_f_reg;
    assign num_f  = num_reg;
    assign den_f  = den_f_reg;

endmodule

>>> src/plcm_div.sv
module plcm_div import plcm_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int NW          = VALUE_WIDTH + 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  stage_ctl_t             ctl_f,
    input  color_t                 dcol_f,
    input  logic [NW-1:0]          num_f [3],
    input  logic [VALUE_WIDTH-1:0] den_f,
    output stage_ctl_t             ctl_q,
    output color_t                 color_q
);

    stage_ctl_t             ctl_reg  [QUOT_BITS];
    color_t                 dcol_reg [QUOT_BITS];
    logic [VALUE_WIDTH-1:0] den_reg  [QUOT_BITS];
    logic [NW-1:0]          rem_reg  [QUOT_BITS][3];
    logic [CH_WIDTH-1:0]    q_reg    [QUOT_BITS][3];

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < QUOT_BITS; s++)
    begin : g_stage
        localparam int K = QUOT_BITS - 1 - s;

        stage_ctl_t             ctl_in;
        color_t                 dcol_in;
        logic [VALUE_WIDTH-1:0] den_in;
        logic [NW-1:0]          rem_in [3];
        logic [CH_WIDTH-1:0]    q_in   [3];
        logic [NW-1:0]          shifted;

        if (s == 0)
        begin : g_first
            assign ctl_in  = ctl_f;
            assign dcol_in = dcol_f;
            assign den_in  = den_f;
            assign rem_in  = num_f;
            assign q_in[0] = '0;
            assign q_in[1] = '0;
            assign q_in[2] = '0;
        end
        else
        begin : g_next
            assign ctl_in  = ctl_reg[s-1];
            assign dcol_in = dcol_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign q_in    = q_reg[s-1];
        end

        assign shifted = NW'(den_in) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[s] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dcol_reg[s] <= dcol_in;
                den_reg[s]  <= den_in;
                for (int c = 0; c < 3; c++)
                begin
                    if (rem_in[c] >= shifted)
                    begin
                        rem_reg[s][c]  <= rem_in[c] - shifted;
                        q_reg[s][c]    <= q_in[c] | CH_WIDTH'(1 << K);
                    end
                    else
                    begin
                        rem_reg[s][c] <= rem_in[c];
                        q_reg[s][c]   <= q_in[c];
                    end
                end
            end
        end
    end

    assign ctl_q   = ctl_reg[QUOT_BITS-1];
    assign color_q = ctl_reg[QUOT_BITS-1].direct ? dcol_reg[QUOT_BITS-1] :
                     {q_reg[QUOT_BITS-1][0], q_reg[QUOT_BITS-1][1], q_reg[QUOT_BITS-1][2]};

endmodule

>>> verif/tb_piecewise_linear_color_map_top.sv
module tb_piecewise_linear_color_map_top;
    import plcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = MAX_ENTRIES_DEF;
    localparam int LATENCY = 15;
    localparam int WATCHDOG_LIMIT = 20000;

    // Golden copy of the color table and the active entry count.
    class color_scoreboard;
        logic signed [15:0] bp_table [DEPTH];
        color_t             color_table [DEPTH];
        logic [CFG_WIDTH-1:0] entries_in_use;
        color_t             pending_colors [$];
        int                 mismatches;
        int                 maps_checked;

        function void clear();
            for (int k = 0; k < DEPTH; k++)
            begin
                bp_table[k] = '0;
                color_table[k] = '0;
            end
            entries_in_use = CFG_WIDTH'(CFG_RESET);
            mismatches = 0;
            maps_checked = 0;
        endfunction

        function color_t blend_color(logic signed [15:0] v);
            int n;
            int i;
            int d0;
            int d1;
            int sum;
            int q;
            color_t lo;
            color_t hi;
            color_t res;
            n = entries_in_use;
            if (n < N_MIN)
                n = N_MIN;
            if (n > DEPTH)
                n = DEPTH;
            if (v <= bp_table[0])
                return color_table[0];
            i = 1;
            while (i < n && v > bp_table[i])
                i++;
            if (i >= n)
                return color_table[n-1];
            d0 = int'(v) - int'(bp_table[i-1]);
            d1 = int'(bp_table[i]) - int'(v);
            sum = d0 + d1;
            lo = color_table[i-1];
            hi = color_table[i];
            if (sum <= 0 || d0 < 0 || d1 < 0)
                return hi;
            q = (int'(lo.red) * d1 + int'(hi.red) * d0) / sum;
            res.red = q[7:0];
            q = (int'(lo.green) * d1 + int'(hi.green) * d0) / sum;
            res.green = q[7:0];
            q = (int'(lo.blue) * d1 + int'(hi.blue) * d0) / sum;
            res.blue = q[7:0];
            return res;
        endfunction

        function void note_sample(logic op, logic signed [15:0] v, logic [3:0] idx,
                                  color_t c);
            if (op == OP_WRITE)
            begin
                bp_table[idx] = v;
                color_table[idx] = c;
            end
            else
                pending_colors.push_back(blend_color(v));
        endfunction

        function void check_color(color_t got);
            color_t want;
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color %h", got);
                return;
            end
            want = pending_colors.pop_front();
            maps_checked++;
            if (got.red !== want.red || got.green !== want.green
                || got.blue !== want.blue)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("color mismatch: expected r%h g%h b%h, got r%h g%h b%h",
                             want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    plcm_in_if  samples ();
    plcm_out_if colors ();
    plcm_cfg_if cfg ();

    piecewise_linear_color_map_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .colors  (colors.source),
        .cfg     (cfg.sink)
    );

    color_scoreboard sb;
    int  idle_cycles;
    bit  hold_off;          // receiver holds off a long stretch while set
    bit  fast_mode;         // no idling on either side

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive one transaction on samples after a random gap; wait for the handshake.
    // Valid stays high after the handshake; the next gap or drain_pipe drops it.
    task automatic send_sample(logic op, logic signed [15:0] v, logic [3:0] idx,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.op <= op;
        samples.value <= v;
        samples.entry_index <= idx;
        samples.red_in <= r;
        samples.green_in <= g;
        samples.blue_in <= b;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        sb.note_sample(op, v, idx, '{red: r, green: g, blue: b});
    endtask

    task automatic write_entry(int idx, logic signed [15:0] bp);
        send_sample(OP_WRITE, bp, idx[3:0], 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic map_value(logic signed [15:0] v);
        send_sample(OP_MAP, v, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Wait for every expected color, then let the pipe drain before a register write.
    task automatic drain_pipe();
        samples.valid <= 1'b0;
        while (sb.pending_colors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_WIDTH-1:0] n);
        drain_pipe();
        cfg.valid <= 1'b1;
        cfg.data <= n;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.entries_in_use = n;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Load a nondecreasing table over n entries with random spacing.
    task automatic load_ramp(int n);
        int bp;
        bp = $urandom_range(0, 1) ? -32768 + $urandom_range(0, 2000)
                                  : $signed($urandom_range(0, 20000)) - 10000;
        for (int k = 0; k < n; k++)
        begin
            write_entry(k, bp[15:0]);
            bp = bp + $urandom_range(0, 4000);
            if (bp > 32767)
                bp = 32767;
        end
    endtask

    // Map value: half from the lowest breakpoint up, 3 in 10 near one, rest anywhere.
    task automatic random_map();
        int pick;
        int k;
        int v;
        pick = $urandom_range(0, 9);
        k = $urandom_range(0, DEPTH - 1);
        if (pick < 3)
            v = int'(sb.bp_table[k]) + $signed($urandom_range(0, 2)) - 1;
        else if (pick < 8)
            v = int'(sb.bp_table[0]) + $urandom_range(0, 40000);
        else
            v = $signed($urandom_range(0, 65535)) - 32768;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        map_value(v[15:0]);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int gap;
        colors.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                colors.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = fast_mode ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                colors.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            colors.ready <= 1'b1;
            @(posedge clk);
            while (!colors.valid)
                @(posedge clk);
        end
    end

    // Monitor: check each accepted color; count cycles with no transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (colors.valid && colors.ready)
                sb.check_color('{red: colors.red_out, green: colors.green_out,
                                 blue: colors.blue_out});
            if ((colors.valid && colors.ready) || (samples.valid && samples.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired");
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        sb.clear();
        idle_cycles = 0;
        hold_off = 1'b0;
        fast_mode = 1'b0;
        rst_n = 1'b0;
        samples.valid <= 1'b0;
        samples.op <= OP_MAP;
        samples.value <= '0;
        samples.entry_index <= '0;
        samples.red_in <= '0;
        samples.green_in <= '0;
        samples.blue_in <= '0;
        cfg.valid <= 1'b0;
        cfg.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset table, extremes, write past active count, equal breakpoints.
        map_value(16'sh8000);
        map_value(16'sh7fff);
        map_value(16'sh0000);
        send_sample(OP_WRITE, 16'sh8000, 4'd0, 8'hff, 8'h00, 8'hff);
        send_sample(OP_WRITE, 16'sh7fff, 4'd1, 8'h00, 8'hff, 8'h00);
        map_value(16'sh8000);
        map_value(16'sh8001);
        map_value(16'sh0000);
        map_value(16'sh7ffe);
        map_value(16'sh7fff);
        send_sample(OP_WRITE, 16'sh0100, 4'd2, 8'h12, 8'h34, 8'h56);
        send_sample(OP_WRITE, 16'sh0100, 4'd3, 8'hab, 8'hcd, 8'hef);
        send_sample(OP_WRITE, 16'sh0100, 4'd15, 8'hff, 8'hff, 8'hff);
        write_count(5'd4);
        map_value(16'sh0100);
        map_value(16'sh0101);
        map_value(16'sh00ff);
        map_value(16'sh7fff);
        write_count(5'd0);
        map_value(16'sh0050);
        write_count(5'd31);
        map_value(16'sh7fff);
        map_value(16'sh0101);

        // Random phases across several entry counts, extremes among them.
        for (int phase = 0; phase < 8; phase++)
        begin
            int n;
            case (phase)
                0: n = 2;
                1: n = 16;
                2: n = 31;
                3: n = 1;
                default: n = $urandom_range(0, 31);
            endcase
            write_count(n[4:0]);
            load_ramp(DEPTH);
            fast_mode = (phase == 5);
            if (phase == 2)
                hold_off = 1'b1;
            for (int k = 0; k < 125; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_sample(OP_WRITE, 16'($urandom_range(0, 65535)),
                                4'($urandom_range(0, 15)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                else
                    random_map();
            end
            fast_mode = 1'b0;
        end

        drain_pipe();
        $display("ran directed table edges and 8 random phases over entry counts 0..31");
        $display("colors checked: %0d, mismatches: %0d", sb.maps_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_colors.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> piecewise_linear_color_map_top.f
+incdir+src
src/plcm_pkg.sv
src/plcm_if.sv
src/plcm_search.sv
src/plcm_blend.sv
src/plcm_div.sv
src/piecewise_linear_color_map_top.sv
verif/tb_piecewise_linear_color_map_top.sv
